// ===== rtl/core/line_follower_pid_drive_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line follower PID drive.
// Each macro expands to one labelled concurrent assertion clocked on clk and
// disabled while rst is high; the enclosing module must provide both.
// ----------------------------------------------------------------------------
`ifndef LINE_FOLLOWER_PID_DRIVE_ASSERT_SVH
`define LINE_FOLLOWER_PID_DRIVE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define LFPD_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// The condition must hold in the cycle after the trigger.
`define LFPD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/core/lfpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, register codes, reset values and pipeline control types for
// the line follower PID drive.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  // Default parameter values.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int DUTY_BITS_DEF   = 10;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register widths.
  localparam int GAIN_W        = 16;
  localparam int SPEED_CFG_W   = 10;
  localparam int WSIDE_W       = 15;
  localparam int WEIGHT_W      = 16;
  localparam int LANE_WEIGHT_W = 17;

  // Datapath widths.
  localparam int ERR_W   = 16;
  localparam int DERIV_W = 17;
  localparam int INTEG_W = 32;
  localparam int PID_W   = 16;
  localparam int SPEED_W = 17;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_PROP     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_INTEG    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_DERIV    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_BASE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_CEILING = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_FLOOR   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_SIDE   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_WEIGHT_CENTRE = 3'd7;

  // Register reset values.
  localparam logic [GAIN_W-1:0]          GAIN_PROP_RST     = 16'd512;
  localparam logic [GAIN_W-1:0]          GAIN_INTEG_RST    = 16'd51;
  localparam logic [GAIN_W-1:0]          GAIN_DERIV_RST    = 16'd1024;
  localparam logic [SPEED_CFG_W-1:0]     SPEED_BASE_RST    = 10'd800;
  localparam logic [SPEED_CFG_W-1:0]     SPEED_CEILING_RST = 10'd1023;
  localparam logic [SPEED_CFG_W-1:0]     SPEED_FLOOR_RST   = 10'd770;
  localparam logic [WSIDE_W-1:0]         WEIGHT_SIDE_RST   = 15'd12800;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_CENTRE_RST = 16'sd26;

  // Saturation limits of the 16-bit signed error and PID output.
  localparam logic signed [ERR_W-1:0] ERR_MAX = 16'sh7FFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 16'sh8000;

  // Division by five as a multiply by a rounded-up reciprocal; exact for
  // dividends below two to the power of the shift.
  localparam int DIV5_SHIFT = 26;
  localparam int DIV5_W     = 24;
  localparam logic [DIV5_W-1:0] DIV5_RECIP = DIV5_W'(((1 << DIV5_SHIFT) + 4) / 5);

  // Control bits that travel alongside each pipeline stage.
  typedef struct packed {
    logic valid;
    logic line;
    logic stop;
  } lfpd_ctl_t;

endpackage

// ===== rtl/core/lfpd_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd interfaces
// Valid/ready channels for sensor samples, drive results and register writes.
// ----------------------------------------------------------------------------

// Three raw IR samples per transaction.
interface lfpd_sensor_if #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sensor_left;
  logic [SAMPLE_BITS-1:0] sensor_middle;
  logic [SAMPLE_BITS-1:0] sensor_right;

  modport source (output valid, sensor_left, sensor_middle, sensor_right, input ready);
  modport sink   (input valid, sensor_left, sensor_middle, sensor_right, output ready);
endinterface

// Motor duties, flags and PID correction per transaction.
interface lfpd_drive_if #(
  parameter int DUTY_BITS = lfpd_pkg::DUTY_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic [DUTY_BITS-1:0]                duty_left;
  logic [DUTY_BITS-1:0]                duty_right;
  logic                                brake;
  logic                                line_seen;
  logic signed [lfpd_pkg::PID_W-1:0]   correction;

  modport source (output valid, duty_left, duty_right, brake, line_seen, correction,
                  input ready);
  modport sink   (input valid, duty_left, duty_right, brake, line_seen, correction,
                  output ready);
endinterface

// Register write channel.
interface lfpd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [lfpd_pkg::CFG_INDEX_W-1:0]    index;
  logic [lfpd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/line_follower_pid_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_pid_drive
// Three-sensor PID line follower producing left and right motor duties.
// ----------------------------------------------------------------------------
// The block takes one sensor transaction per clock cycle while the drive side
// keeps up, and each result is registered through one lane stage, three
// stages forming the error (sum, reciprocal multiply, correction), five PID
// stages and the output register before it is offered on the drive side. The
// integrator, the previous error and the held speeds each update within a
// single stage, so back-to-back transactions see the state left by the one
// before. When a result waits at the output the whole pipeline holds and
// sensors.ready drops in the same cycle. The configuration port is always
// ready; write registers only while no transaction is in flight.
module line_follower_pid_drive #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF,
  parameter int DUTY_BITS   = lfpd_pkg::DUTY_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lfpd_cfg_if.sink     cfg,
  lfpd_sensor_if.sink  sensors,
  lfpd_drive_if.source drive
);
  import lfpd_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + 17;

  // Configuration registers.
  logic [GAIN_W-1:0]          gain_prop, gain_integ, gain_deriv;
  logic [SPEED_CFG_W-1:0]     speed_base, speed_ceiling, speed_floor;
  logic [WSIDE_W-1:0]         weight_side;
  logic signed [WEIGHT_W-1:0] weight_centre;

  logic adv;
  logic valid1;
  logic signed [LANE_WEIGHT_W-1:0] w_left, w_mid, w_right;
  logic signed [PROD_W-1:0] prod_left, prod_mid, prod_right;
  logic full_left, full_mid, full_right, zero_left, zero_mid, zero_right;
  lfpd_ctl_t ctl_err, ctl_pid;
  logic signed [ERR_W-1:0] err;
  logic signed [PID_W-1:0] pid;

  // Register writes.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= GAIN_PROP_RST;
      gain_integ    <= GAIN_INTEG_RST;
      gain_deriv    <= GAIN_DERIV_RST;
      speed_base    <= SPEED_BASE_RST;
      speed_ceiling <= SPEED_CEILING_RST;
      speed_floor   <= SPEED_FLOOR_RST;
      weight_side   <= WEIGHT_SIDE_RST;
      weight_centre <= WEIGHT_CENTRE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GAIN_PROP:     gain_prop     <= cfg.data[GAIN_W-1:0];
        REG_GAIN_INTEG:    gain_integ    <= cfg.data[GAIN_W-1:0];
        REG_GAIN_DERIV:    gain_deriv    <= cfg.data[GAIN_W-1:0];
        REG_SPEED_BASE:    speed_base    <= cfg.data[SPEED_CFG_W-1:0];
        REG_SPEED_CEILING: speed_ceiling <= cfg.data[SPEED_CFG_W-1:0];
        REG_SPEED_FLOOR:   speed_floor   <= cfg.data[SPEED_CFG_W-1:0];
        REG_WEIGHT_SIDE:   weight_side   <= cfg.data[WSIDE_W-1:0];
        REG_WEIGHT_CENTRE: weight_centre <= $signed(cfg.data[WEIGHT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the output register is empty or being taken.
  assign adv           = !drive.valid || drive.ready;
  assign sensors.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (adv) begin
      valid1 <= sensors.valid;
    end
  end

  // Lane weights: the side weight negated on the left.
  assign w_left  = -$signed({2'b00, weight_side});
  assign w_right = $signed({2'b00, weight_side});
  assign w_mid   = LANE_WEIGHT_W'(weight_centre);

  lfpd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_left (
    .clk     (clk),
    .adv     (adv),
    .sample  (sensors.sensor_left),
    .weight  (w_left),
    .prod    (prod_left),
    .is_full (full_left),
    .is_zero (zero_left)
  );

  lfpd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_mid (
    .clk     (clk),
    .adv     (adv),
    .sample  (sensors.sensor_middle),
    .weight  (w_mid),
    .prod    (prod_mid),
    .is_full (full_mid),
    .is_zero (zero_mid)
  );

  lfpd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_right (
    .clk     (clk),
    .adv     (adv),
    .sample  (sensors.sensor_right),
    .weight  (w_right),
    .prod    (prod_right),
    .is_full (full_right),
    .is_zero (zero_right)
  );

  lfpd_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .valid_in   (valid1),
    .prod_left  (prod_left),
    .prod_mid   (prod_mid),
    .prod_right (prod_right),
    .full_left  (full_left),
    .full_mid   (full_mid),
    .full_right (full_right),
    .zero_left  (zero_left),
    .zero_mid   (zero_mid),
    .zero_right (zero_right),
    .ctl_out    (ctl_err),
    .err        (err)
  );

  lfpd_pid u_pid (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ctl_in     (ctl_err),
    .err_in     (err),
    .gain_prop  (gain_prop),
    .gain_integ (gain_integ),
    .gain_deriv (gain_deriv),
    .ctl_out    (ctl_pid),
    .pid        (pid)
  );

  lfpd_drive #(.DUTY_BITS(DUTY_BITS)) u_drive (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .ctl_in        (ctl_pid),
    .pid           (pid),
    .speed_base    (speed_base),
    .speed_ceiling (speed_ceiling),
    .speed_floor   (speed_floor),
    .out_ch        (drive)
  );

endmodule

// ===== rtl/core/lfpd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_lane
// One sensor lane: weights a raw sample and flags full scale and zero.
// ----------------------------------------------------------------------------
module lfpd_lane #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      adv,
  input  logic [SAMPLE_BITS-1:0]                    sample,
  input  logic signed [lfpd_pkg::LANE_WEIGHT_W-1:0] weight,
  output logic signed [SAMPLE_BITS+16:0]            prod,
  output logic                                      is_full,
  output logic                                      is_zero
);
  import lfpd_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + 17;
  localparam int FULL_W = SAMPLE_BITS + LANE_WEIGHT_W + 1;

  logic signed [FULL_W-1:0] product;

  // Signed weight times the sample taken as a non-negative value.
  assign product = $signed(FULL_W'({1'b0, sample})) * FULL_W'(weight);

  // Lane register; its magnitude always fits the narrower product width.
  always_ff @(posedge clk) begin
    if (adv) begin
      prod    <= product[PROD_W-1:0];
      is_full <= (sample == {SAMPLE_BITS{1'b1}});
      is_zero <= (sample == '0);
    end
  end

endmodule

// ===== rtl/core/lfpd_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_merge
// Combines the three lane results into line flags and the Q8.8 position
// error, dividing by full scale through a reciprocal multiply.
// ----------------------------------------------------------------------------
module lfpd_merge #(
  parameter int SAMPLE_BITS = lfpd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              valid_in,
  input  logic signed [SAMPLE_BITS+16:0]    prod_left,
  input  logic signed [SAMPLE_BITS+16:0]    prod_mid,
  input  logic signed [SAMPLE_BITS+16:0]    prod_right,
  input  logic                              full_left,
  input  logic                              full_mid,
  input  logic                              full_right,
  input  logic                              zero_left,
  input  logic                              zero_mid,
  input  logic                              zero_right,
  output lfpd_pkg::lfpd_ctl_t               ctl_out,
  output logic signed [lfpd_pkg::ERR_W-1:0] err
);
  import lfpd_pkg::*;

  localparam int NUM_W   = SAMPLE_BITS + 19;
  localparam int A_W     = SAMPLE_BITS + 15;
  localparam int RECIP_W = 33 - SAMPLE_BITS;
  localparam int QP_W    = A_W + RECIP_W;
  localparam int FRAC    = 32;
  localparam int Q_W     = QP_W - FRAC;
  localparam int QF_W    = Q_W + SAMPLE_BITS;
  localparam int FS      = (1 << SAMPLE_BITS) - 1;
  localparam logic [NUM_W-1:0]   SAT_LIM = NUM_W'(FS) << 15;
  localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(64'h1_0000_0000 / 64'(FS));

  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic                    neg, sat, line, centre, stop;

  lfpd_ctl_t  ctl2, ctl3;
  logic [A_W-1:0] a2, a3;
  logic       neg2, sat2, errz2, neg3, sat3, errz3;

  logic [QP_W-1:0] qprod;
  logic [Q_W-1:0]  q3, q_fix;
  logic [QF_W-1:0] qfs, rem;
  logic signed [ERR_W-1:0] err_next;

  // Merge: sum of lane products, magnitude and line flags.
  always_comb begin
    num    = NUM_W'(prod_left) + NUM_W'(prod_mid) + NUM_W'(prod_right);
    neg    = num[NUM_W-1];
    mag    = neg ? $unsigned(-num) : $unsigned(num);
    sat    = (mag >= SAT_LIM);
    line   = !(full_left && full_mid && full_right);
    centre = full_left && full_right && !full_mid;
    stop   = zero_left && zero_mid && zero_right;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2 <= '0;
    end else if (adv) begin
      ctl2 <= '{valid: valid_in, line: line, stop: stop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2    <= mag[A_W-1:0];
      neg2  <= neg;
      sat2  <= sat;
      errz2 <= !line || centre;
    end
  end

  // Quotient estimate by reciprocal of full scale; at most one short.
  assign qprod = QP_W'(a2) * QP_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (adv) begin
      ctl3 <= ctl2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q3    <= qprod[QP_W-1:FRAC];
      a3    <= a2;
      neg3  <= neg2;
      sat3  <= sat2;
      errz3 <= errz2;
    end
  end

  // Correction step, then sign, saturation and the zero-error cases.
  always_comb begin
    qfs   = {q3, {SAMPLE_BITS{1'b0}}} - QF_W'(q3);
    rem   = QF_W'(a3) - qfs;
    q_fix = q3 + Q_W'(rem >= QF_W'(FS));
    if (errz3) begin
      err_next = '0;
    end else if (sat3) begin
      err_next = neg3 ? ERR_MIN : ERR_MAX;
    end else if (neg3) begin
      err_next = -$signed(q_fix);
    end else begin
      err_next = $signed(q_fix);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err <= err_next;
    end
  end

endmodule

// ===== rtl/core/lfpd_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pid
// PID on the position error: saturating integrator cleared on stop,
// derivative from the previous error, gains applied in Q8.8.
// ----------------------------------------------------------------------------
module lfpd_pid (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  lfpd_pkg::lfpd_ctl_t                ctl_in,
  input  logic signed [lfpd_pkg::ERR_W-1:0]  err_in,
  input  logic [lfpd_pkg::GAIN_W-1:0]        gain_prop,
  input  logic [lfpd_pkg::GAIN_W-1:0]        gain_integ,
  input  logic [lfpd_pkg::GAIN_W-1:0]        gain_deriv,
  output lfpd_pkg::lfpd_ctl_t                ctl_out,
  output logic signed [lfpd_pkg::PID_W-1:0]  pid
);
  import lfpd_pkg::*;

  localparam int XM_W      = ERR_W + 7;
  localparam int XP_W      = XM_W + DIV5_W;
  localparam int Q5_W      = XP_W - DIV5_SHIFT;
  localparam int QS_W      = Q5_W + 1;
  localparam int ISUM_W    = INTEG_W + 1;
  localparam int PP_W      = GAIN_W + ERR_W + 2;
  localparam int PD_W      = GAIN_W + DERIV_W + 2;
  localparam int PI_W      = GAIN_W + INTEG_W + 1;
  localparam int SUM_W     = PI_W + 1;
  localparam int PID_SHIFT = 24;
  localparam int SH_W      = SUM_W - PID_SHIFT;
  localparam logic signed [SUM_W-1:0] ROUND_BIAS = SUM_W'((1 << PID_SHIFT) - 1);
  localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;

  // Loop state.
  logic signed [INTEG_W-1:0] integ_acc;
  logic signed [ERR_W-1:0]   last_error;

  logic [DERIV_W-1:0]        err_abs;
  logic [XM_W-1:0]           xm;
  logic [XP_W-1:0]           xprod;
  logic signed [DERIV_W-1:0] deriv_next;

  lfpd_ctl_t ctl5, ctl6, ctl7, ctl8;
  logic [Q5_W-1:0]           q5;
  logic                      neg5;
  logic signed [ERR_W-1:0]   err5, err6;
  logic signed [DERIV_W-1:0] deriv5, deriv6;

  logic signed [QS_W-1:0]    qs;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [INTEG_W-1:0] integ_next, integ6;

  logic signed [PP_W-1:0]  pp;
  logic signed [PD_W-1:0]  pd;
  logic signed [PI_W-1:0]  pi_term;
  logic signed [SUM_W-1:0] sum8, adj;
  logic signed [SH_W-1:0]  sh;
  logic signed [PID_W-1:0] pid_next;

  // Stage five: error times 256/20 as |error|*64/5, and the derivative.
  always_comb begin
    err_abs    = err_in[ERR_W-1] ? $unsigned(-DERIV_W'(err_in)) : $unsigned(DERIV_W'(err_in));
    xm         = {err_abs, 6'b0};
    xprod      = XP_W'(xm) * XP_W'(DIV5_RECIP);
    deriv_next = DERIV_W'(err_in) - DERIV_W'(last_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      ctl5       <= '0;
    end else if (adv) begin
      ctl5 <= ctl_in;
      if (ctl_in.valid) begin
        last_error <= err_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q5     <= xprod[XP_W-1:DIV5_SHIFT];
      neg5   <= err_in[ERR_W-1];
      err5   <= err_in;
      deriv5 <= deriv_next;
    end
  end

  // Stage six: saturating integrator update, cleared after a stop.
  always_comb begin
    qs   = neg5 ? -$signed({1'b0, q5}) : $signed({1'b0, q5});
    isum = ISUM_W'(integ_acc) + ISUM_W'(qs);
    if (isum[ISUM_W-1] != isum[ISUM_W-2]) begin
      integ_next = isum[ISUM_W-1] ? INTEG_MIN : INTEG_MAX;
    end else begin
      integ_next = isum[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc <= '0;
      ctl6      <= '0;
    end else if (adv) begin
      ctl6 <= ctl5;
      if (ctl5.valid) begin
        integ_acc <= ctl5.stop ? '0 : integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      integ6 <= integ_next;
      err6   <= err5;
      deriv6 <= deriv5;
    end
  end

  // Stage seven: the three gain products side by side.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl7 <= '0;
    end else if (adv) begin
      ctl7 <= ctl6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp      <= $signed(PP_W'({1'b0, gain_prop})) * PP_W'(err6);
      pd      <= $signed(PD_W'({1'b0, gain_deriv})) * PD_W'(deriv6);
      pi_term <= $signed(PI_W'({1'b0, gain_integ})) * PI_W'(integ6);
    end
  end

  // Stage eight: Q26.24 sum of the three terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl8 <= '0;
    end else if (adv) begin
      ctl8 <= ctl7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum8 <= ((SUM_W'(pp) + SUM_W'(pd)) <<< 8) + SUM_W'(pi_term);
    end
  end

  // Stage nine: truncate toward zero, saturate, force zero on stop.
  always_comb begin
    adj = sum8 + (sum8[SUM_W-1] ? ROUND_BIAS : SUM_W'(0));
    sh  = $signed(adj[SUM_W-1:PID_SHIFT]);
    if (ctl8.stop) begin
      pid_next = '0;
    end else if (sh > SH_W'(ERR_MAX)) begin
      pid_next = ERR_MAX;
    end else if (sh < SH_W'(ERR_MIN)) begin
      pid_next = ERR_MIN;
    end else begin
      pid_next = sh[PID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pid <= pid_next;
    end
  end

endmodule

// ===== rtl/core/lfpd_drive.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_drive
// Differential motor speeds with hold when off the line, ceiling clamp and
// floor cut, into the output register.
// ----------------------------------------------------------------------------
module lfpd_drive #(
  parameter int DUTY_BITS = lfpd_pkg::DUTY_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  lfpd_pkg::lfpd_ctl_t                  ctl_in,
  input  logic signed [lfpd_pkg::PID_W-1:0]    pid,
  input  logic [lfpd_pkg::SPEED_CFG_W-1:0]     speed_base,
  input  logic [lfpd_pkg::SPEED_CFG_W-1:0]     speed_ceiling,
  input  logic [lfpd_pkg::SPEED_CFG_W-1:0]     speed_floor,
  lfpd_drive_if.source                         out_ch
);
  import lfpd_pkg::*;

  // Clamp to the ceiling first, then cut anything under the floor to zero.
  function automatic logic [SPEED_CFG_W-1:0] duty_limit(
    input logic signed [SPEED_W-1:0] s,
    input logic [SPEED_CFG_W-1:0]    ceil_v,
    input logic [SPEED_CFG_W-1:0]    floor_v
  );
    logic signed [SPEED_W-1:0] c;
    c = s;
    if (s > $signed(SPEED_W'(ceil_v))) begin
      c = $signed(SPEED_W'(ceil_v));
    end
    if (c < $signed(SPEED_W'(floor_v))) begin
      c = '0;
    end
    return c[SPEED_CFG_W-1:0];
  endfunction

  logic signed [SPEED_W-1:0] held_left, held_right;
  logic signed [SPEED_W-1:0] base_s, speed_left, speed_right;

  logic                      out_valid;
  logic [DUTY_BITS-1:0]      duty_left, duty_right;
  logic                      brake, line_seen;
  logic signed [PID_W-1:0]   correction;

  // Raw speeds: base plus or minus the correction, or the held pair.
  always_comb begin
    base_s = $signed(SPEED_W'(speed_base));
    if (ctl_in.line) begin
      speed_left  = base_s + SPEED_W'(pid);
      speed_right = base_s - SPEED_W'(pid);
    end else begin
      speed_left  = held_left;
      speed_right = held_right;
    end
  end

  // Held speeds follow every on-line transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_left  <= '0;
      held_right <= '0;
    end else if (adv && ctl_in.valid && ctl_in.line) begin
      held_left  <= speed_left;
      held_right <= speed_right;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl_in.valid) begin
      duty_left  <= DUTY_BITS'(duty_limit(speed_left, speed_ceiling, speed_floor));
      duty_right <= DUTY_BITS'(duty_limit(speed_right, speed_ceiling, speed_floor));
      brake      <= ctl_in.stop;
      line_seen  <= ctl_in.line;
      correction <= pid;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.duty_left  = duty_left;
  assign out_ch.duty_right = duty_right;
  assign out_ch.brake      = brake;
  assign out_ch.line_seen  = line_seen;
  assign out_ch.correction = correction;

endmodule

// ===== rtl/core/lfpd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_checker
// Port-level checks on the line follower PID drive, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_follower_pid_drive_assert.svh"

module lfpd_checker #(
  parameter int DUTY_BITS = lfpd_pkg::DUTY_BITS_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [DUTY_BITS-1:0]              duty_left,
  input logic [DUTY_BITS-1:0]              duty_right,
  input logic                              brake,
  input logic                              line_seen,
  input logic signed [lfpd_pkg::PID_W-1:0] correction
);

  // A stalled result stays offered.
  `LFPD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `LFPD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(duty_left) && $stable(duty_right) && $stable(brake) && $stable(line_seen) && $stable(correction), "result changed while stalled")

  // The stop pattern always sees the line and forces a zero correction.
  `LFPD_ASSERT_NOW(a_brake_zero, out_valid && brake, correction == 0 && line_seen, "brake without zero correction")

  // Sample intake only stops when a result is waiting to be taken.
  `LFPD_ASSERT_NOW(a_ready_stall, !in_ready, out_valid && !out_ready, "intake stalled without output back-pressure")

endmodule

bind line_follower_pid_drive lfpd_checker #(.DUTY_BITS(DUTY_BITS)) u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sensors.ready),
  .out_valid  (drive.valid),
  .out_ready  (drive.ready),
  .duty_left  (drive.duty_left),
  .duty_right (drive.duty_right),
  .brake      (drive.brake),
  .line_seen  (drive.line_seen),
  .correction (drive.correction)
);
